FILE: hdl/pcma_pkg.sv
// ----------------------------------------------------------------------------
// Pose clamp moving average package
// Shared pose type, angle widths and fixed angle constants.
// ----------------------------------------------------------------------------
package pcma_pkg;

	// Width of the raw angle inputs and of the internal pre-clamp angle.
	localparam int RAW_W   = 17;
	localparam int TURN_W  = 18;
	localparam int ANGLE_W = 19;

	// Running sums of clamped angles and the divider width that serves them.
	localparam int SUM_W      = 19;
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	// Configuration port.
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int WLEN_W     = 5;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET      = 2'd3;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd8;

	// Angle constants in 1/256 degree.
	localparam logic signed [TURN_W-1:0]  TURN_X  = 18'sd46080;
	localparam logic signed [TURN_W-1:0]  SHIFT_Z = 18'sd23040;
	localparam logic signed [ANGLE_W-1:0] LIMIT_X = 19'sd7680;
	localparam logic signed [ANGLE_W-1:0] LIMIT_Y = 19'sd3840;
	localparam logic signed [ANGLE_W-1:0] LIMIT_Z = 19'sd7680;

	localparam int MOUTH_W = 12;
	localparam logic [MOUTH_W-1:0] OPEN_LEVEL = 12'd51;

	// One clamped pose as held in the window.
	typedef struct packed {
		logic signed [13:0] x;
		logic signed [12:0] y;
		logic signed [13:0] z;
		logic               mouth;
	} pose_t;

endpackage

FILE: hdl/pcma_cell.sv
// ----------------------------------------------------------------------------
// Pose clamp moving average window cell
// Holds one pose of the window and takes its neighbor's pose on a shift.
// ----------------------------------------------------------------------------
module pcma_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift_en,
	input  pcma_pkg::pose_t pose_in,
	output pcma_pkg::pose_t pose_out
);
	import pcma_pkg::*;

	pose_t pose_q;

	// Reset gives the zero closed pose, which the first cell must hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q <= '0;
		end else if (shift_en) begin
			pose_q <= pose_in;
		end
	end

	assign pose_out = pose_q;

endmodule

FILE: hdl/pcma_divider.sv
// ----------------------------------------------------------------------------
// Pose clamp moving average divider
// Signed by unsigned restoring divider, one quotient bit per step, truncating.
// ----------------------------------------------------------------------------
module pcma_divider #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 6
) (
	input  logic                    clk,
	input  logic                    load,
	input  logic                    step,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic signed [NUM_W-1:0] quot
);
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [DEN_W:0]   rem_try;
	logic             fits;

	assign rem_try = {rem_q, quo_q[NUM_W-1]};
	assign fits    = rem_try >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= num[NUM_W-1];
			quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (step) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(rem_try - {1'b0, den_q}) : rem_try[DEN_W-1:0];
		end
	end

	// Magnitude division followed by sign restore truncates toward zero.
	assign quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: hdl/pose_clamp_moving_average_unit.sv
// ----------------------------------------------------------------------------
// Pose clamp moving average unit
// Turns, offsets and clamps head-pose angles and averages them over a window.
// ----------------------------------------------------------------------------
// Usage: one head-pose sample is taken per transfer on the input channel
// (in_valid/in_ready with angle_x, angle_y, angle_z and mouth_level). Each
// sample yields exactly one result transfer on the output channel
// (out_valid/out_ready with mean_x, mean_y, mean_z and mouth_open).
// Between its input transfer and the shown result, an item passes through
// the prep step, the scan that rotates the whole ring of window cells once
// past the accumulator, the load of the dividers and the 19-step restoring
// divide of the sums by the fill count, and then the output register.
// One item is worked on at a time, so a new input transfer is only taken
// once the previous result has left the sequencer. The next input
// transfer is taken as soon as the previous result sits in the output
// register, even while the receiver still stalls it. If the output register
// is still full when a new result is ready, the unit holds that result until
// the receiver takes the old one. Reset leaves the window with one zero
// closed pose, a window length of 8 and zero offsets. Configuration writes
// on cfg_we take effect at once and must only be made while the unit is idle.
// ----------------------------------------------------------------------------
module pose_clamp_moving_average_unit #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcma_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pcma_pkg::RAW_W-1:0]   angle_x,
	input  logic signed [pcma_pkg::RAW_W-1:0]   angle_y,
	input  logic signed [pcma_pkg::RAW_W-1:0]   angle_z,
	input  logic [pcma_pkg::MOUTH_W-1:0]        mouth_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [13:0]                  mean_x,
	output logic signed [12:0]                  mean_y,
	output logic signed [13:0]                  mean_z,
	output logic                                mouth_open
);
	import pcma_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_LOAD = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [WLEN_W-1:0]            wlen_q;
	logic signed [CFG_DATA_W-1:0] x_off_q;
	logic signed [CFG_DATA_W-1:0] y_off_q;
	logic signed [CFG_DATA_W-1:0] z_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WLEN_RESET;
			x_off_q <= '0;
			y_off_q <= '0;
			z_off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: wlen_q  <= cfg_data[WLEN_W-1:0];
				REG_X_OFFSET:      x_off_q <= cfg_data;
				REG_Y_OFFSET:      y_off_q <= cfg_data;
				REG_Z_OFFSET:      z_off_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// First stage: the X angle is turned by half a circle toward zero, Y is
	// negated and Z is moved down by a quarter circle.
	logic signed [TURN_W-1:0] turn_x_s1;
	logic signed [TURN_W-1:0] turn_y_s1;
	logic signed [TURN_W-1:0] turn_z_s1;
	logic                     mouth_s1;
	logic                     in_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			turn_x_s1 <= (angle_x > 0) ? TURN_W'(angle_x) - TURN_X
			                           : TURN_W'(angle_x) + TURN_X;
			turn_y_s1 <= -TURN_W'(angle_y);
			turn_z_s1 <= TURN_W'(angle_z) - SHIFT_Z;
			mouth_s1  <= mouth_level > OPEN_LEVEL;
		end
	end

	// Second step: add the offsets and clamp each axis to its limit.
	logic signed [ANGLE_W-1:0] off_x;
	logic signed [ANGLE_W-1:0] off_y;
	logic signed [ANGLE_W-1:0] off_z;
	pose_t                     new_pose;

	assign off_x = ANGLE_W'(turn_x_s1) + ANGLE_W'(x_off_q);
	assign off_y = ANGLE_W'(turn_y_s1) + ANGLE_W'(y_off_q);
	assign off_z = ANGLE_W'(turn_z_s1) + ANGLE_W'(z_off_q);

	always_comb begin
		if (off_x > LIMIT_X) begin
			new_pose.x = LIMIT_X[13:0];
		end else if (off_x < -LIMIT_X) begin
			new_pose.x = 14'(-LIMIT_X);
		end else begin
			new_pose.x = off_x[13:0];
		end
		if (off_y > LIMIT_Y) begin
			new_pose.y = LIMIT_Y[12:0];
		end else if (off_y < -LIMIT_Y) begin
			new_pose.y = 13'(-LIMIT_Y);
		end else begin
			new_pose.y = off_y[12:0];
		end
		if (off_z > LIMIT_Z) begin
			new_pose.z = LIMIT_Z[13:0];
		end else if (off_z < -LIMIT_Z) begin
			new_pose.z = 14'(-LIMIT_Z);
		end else begin
			new_pose.z = off_z[13:0];
		end
		new_pose.mouth = mouth_s1;
	end

	// Effective window length: zero counts as one, and it never exceeds the
	// ring depth.
	logic [FILL_W-1:0] wlen_ext;
	logic [FILL_W-1:0] len_eff;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_keep;

	assign wlen_ext  = FILL_W'(wlen_q);
	assign len_eff   = (wlen_q == '0) ? FILL_W'(1)
	                 : (wlen_ext > FILL_W'(WINDOW_DEPTH)) ? FILL_W'(WINDOW_DEPTH) : wlen_ext;
	// The oldest poses fall off the far end of the chain; only the count of
	// live cells has to shrink before the new pose goes in.
	assign fill_keep = (fill_q >= len_eff) ? len_eff - FILL_W'(1) : fill_q;

	// The ring of window cells. The newest pose lives in cell zero. During
	// the prep step the new pose is shifted in; during the scan the ring
	// rotates a full turn so every cell passes the tail once and returns
	// to its place.
	pose_t cell_in  [WINDOW_DEPTH];
	pose_t cell_out [WINDOW_DEPTH];
	logic  shift_en;
	pose_t tail;

	assign shift_en = (state_q == ST_PREP) || (state_q == ST_SCAN);
	assign tail     = cell_out[WINDOW_DEPTH-1];
	assign cell_in[0] = (state_q == ST_PREP) ? new_pose : tail;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign cell_in[i] = cell_out[i-1];
		end
		pcma_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.pose_in  (cell_in[i]),
			.pose_out (cell_out[i])
		);
	end

	// At scan step k the tail holds the pose of cell DEPTH-1-k, which is in
	// the window when that position is below the fill count.
	logic [CNT_W-1:0]  scan_cnt_q;
	logic [FILL_W:0]   scan_pos;
	logic              scan_take;
	logic              scan_last;

	assign scan_pos  = (FILL_W+1)'(scan_cnt_q) + (FILL_W+1)'(fill_q);
	assign scan_take = scan_pos >= (FILL_W+1)'(WINDOW_DEPTH);
	assign scan_last = scan_cnt_q == CNT_W'(WINDOW_DEPTH - 1);

	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-2:0] sum_y_q;
	logic signed [SUM_W-1:0] sum_z_q;
	logic                    all_open_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			sum_z_q    <= '0;
			all_open_q <= 1'b1;
		end else if (state_q == ST_SCAN && scan_take) begin
			sum_x_q    <= sum_x_q + SUM_W'(tail.x);
			sum_y_q    <= sum_y_q + (SUM_W-1)'(tail.y);
			sum_z_q    <= sum_z_q + SUM_W'(tail.z);
			all_open_q <= all_open_q && tail.mouth;
		end
	end

	// Three dividers run side by side on the sums.
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic                    div_load;
	logic                    div_step;
	logic signed [SUM_W-1:0] quot_x;
	logic signed [SUM_W-1:0] quot_y;
	logic signed [SUM_W-1:0] quot_z;

	assign div_load = (state_q == ST_LOAD);
	assign div_step = (state_q == ST_DIV);

	pcma_divider #(.NUM_W(SUM_W), .DEN_W(FILL_W)) u_div_x (
		.clk  (clk),
		.load (div_load),
		.step (div_step),
		.num  (sum_x_q),
		.den  (fill_q),
		.quot (quot_x)
	);

	pcma_divider #(.NUM_W(SUM_W), .DEN_W(FILL_W)) u_div_y (
		.clk  (clk),
		.load (div_load),
		.step (div_step),
		.num  (SUM_W'(sum_y_q)),
		.den  (fill_q),
		.quot (quot_y)
	);

	pcma_divider #(.NUM_W(SUM_W), .DEN_W(FILL_W)) u_div_z (
		.clk  (clk),
		.load (div_load),
		.step (div_step),
		.num  (sum_z_q),
		.den  (fill_q),
		.quot (quot_z)
	);

	// Output register parts the result from the sequencer.
	logic out_load;
	logic out_valid_q;

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_x     <= quot_x[13:0];
			mean_y     <= quot_y[12:0];
			mean_z     <= quot_z[13:0];
			mouth_open <= all_open_q;
		end
	end

	assign out_valid = out_valid_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= FILL_W'(1);
			scan_cnt_q <= '0;
			div_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					fill_q     <= fill_keep + FILL_W'(1);
					scan_cnt_q <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					if (scan_last) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/pose_clamp_moving_average_unit_tb.sv
// ----------------------------------------------------------------------------
// Pose clamp moving average unit testbench
// Drives head-pose samples through the unit under random handshake pressure
// and compares every window mean with a cycle-free software copy of the unit.
// ----------------------------------------------------------------------------
module pose_clamp_moving_average_unit_tb;

	import pcma_pkg::*;

	localparam int WINDOW_DEPTH = 32;
	// Input transfer to result shown: one scan of the ring plus the divide.
	localparam int UNIT_LATENCY = WINDOW_DEPTH + 22;

	// One raw head-pose sample as it is presented on the input channel.
	typedef struct {
		logic signed [RAW_W-1:0] ax;
		logic signed [RAW_W-1:0] ay;
		logic signed [RAW_W-1:0] az;
		logic [MOUTH_W-1:0]      lvl;
	} pose_sample_t;

	// One window mean as it is expected on the output channel.
	typedef struct {
		logic signed [13:0] mx;
		logic signed [12:0] my;
		logic signed [13:0] mz;
		logic               mo;
	} window_mean_t;

	// Every input of the unit starts at a known value, reset included.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [RAW_W-1:0] angle_x = '0;
	logic signed [RAW_W-1:0] angle_y = '0;
	logic signed [RAW_W-1:0] angle_z = '0;
	logic [MOUTH_W-1:0] mouth_level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [13:0] mean_x;
	logic signed [12:0] mean_y;
	logic signed [13:0] mean_z;
	logic mouth_open;

	// Samples waiting for the driver, and means waiting for the monitor.
	pose_sample_t pose_queue[$];
	window_mean_t expected_means[$];
	pose_sample_t next_pose;

	// Percent of cycles in which the sender holds back or the receiver stalls.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;

	// Our own copy of the configuration registers, at their reset values.
	logic [WLEN_W-1:0] win_len = WLEN_RESET;
	logic signed [CFG_DATA_W-1:0] off_x = '0;
	logic signed [CFG_DATA_W-1:0] off_y = '0;
	logic signed [CFG_DATA_W-1:0] off_z = '0;

	// Our own copy of the window. After reset the ring holds one zero pose
	// that counts as closed, so the first mean divides by two.
	int win_x[WINDOW_DEPTH];
	int win_y[WINDOW_DEPTH];
	int win_z[WINDOW_DEPTH];
	bit win_open[WINDOW_DEPTH];
	int held = 1;
	int oldest = 0;
	int sum_x = 0;
	int sum_y = 0;
	int sum_z = 0;
	int open_cnt = 0;

	pose_clamp_moving_average_unit #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.angle_x(angle_x),
		.angle_y(angle_y),
		.angle_z(angle_z),
		.mouth_level(mouth_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_x(mean_x),
		.mean_y(mean_y),
		.mean_z(mean_z),
		.mouth_open(mouth_open)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Every mismatch is printed on one line and counted.
	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic int clip(input int v, input int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Works out the mean that one accepted sample produces and files it.
	// The X angle is turned by half a circle toward zero (a zero X counts as
	// not positive), Y is mirrored and Z is pulled back by a quarter turn.
	task automatic fold_pose(input pose_sample_t s);
		int x;
		int y;
		int z;
		int len;
		int slot;
		bit open;
		window_mean_t m;
		x = s.ax;
		y = s.ay;
		z = s.az;
		open = (s.lvl > OPEN_LEVEL);
		if (x > 0)
			x = x - int'(TURN_X);
		else
			x = x + int'(TURN_X);
		y = -y;
		z = z - int'(SHIFT_Z);
		x = clip(x + int'(off_x), int'(LIMIT_X));
		y = clip(y + int'(off_y), int'(LIMIT_Y));
		z = clip(z + int'(off_z), int'(LIMIT_Z));

		// A length of zero acts as one; the ring bounds it from above.
		len = win_len;
		if (len < 1)
			len = 1;
		if (len > WINDOW_DEPTH)
			len = WINDOW_DEPTH;

		// Drop the oldest poses until the new one fits. After the length
		// has shrunk this drops several poses at once.
		while (held >= len) begin
			sum_x -= win_x[oldest];
			sum_y -= win_y[oldest];
			sum_z -= win_z[oldest];
			if (win_open[oldest])
				open_cnt--;
			oldest = (oldest + 1) % WINDOW_DEPTH;
			held--;
		end

		slot = (oldest + held) % WINDOW_DEPTH;
		win_x[slot] = x;
		win_y[slot] = y;
		win_z[slot] = z;
		win_open[slot] = open;
		sum_x += x;
		sum_y += y;
		sum_z += z;
		if (open)
			open_cnt++;
		held++;

		// Integer division of int values truncates toward zero.
		m.mx = 14'(sum_x / held);
		m.my = 13'(sum_y / held);
		m.mz = 14'(sum_z / held);
		m.mo = (open_cnt == held);
		expected_means.push_back(m);
	endtask

	// Driver: presents queued samples, holds each one until its transfer,
	// and predicts the mean at the edge where the transfer takes place.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			angle_x <= '0;
			angle_y <= '0;
			angle_z <= '0;
			mouth_level <= '0;
		end else begin
			if (in_valid && in_ready)
				fold_pose('{angle_x, angle_y, angle_z, mouth_level});
			// The payload may only change once the current sample is gone.
			if (!in_valid || in_ready) begin
				if (pose_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pose = pose_queue.pop_front();
					in_valid <= 1'b1;
					angle_x <= next_pose.ax;
					angle_y <= next_pose.ay;
					angle_z <= next_pose.az;
					mouth_level <= next_pose.lvl;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls the output at random and checks each result transfer
	// against the oldest prediction, field by field.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_means.size() == 0) begin
					note_mismatch("result transfer with no sample pending");
				end else begin
					window_mean_t m;
					m = expected_means.pop_front();
					if (mean_x !== m.mx)
						note_mismatch($sformatf("mean_x %0d, expected %0d", mean_x, m.mx));
					if (mean_y !== m.my)
						note_mismatch($sformatf("mean_y %0d, expected %0d", mean_y, m.my));
					if (mean_z !== m.mz)
						note_mismatch($sformatf("mean_z %0d, expected %0d", mean_z, m.mz));
					if (mouth_open !== m.mo)
						note_mismatch($sformatf("mouth_open %0b, expected %0b",
							mouth_open, m.mo));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_pose(input int ax, input int ay, input int az, input int lvl);
		pose_sample_t s;
		s.ax = RAW_W'(ax);
		s.ay = RAW_W'(ay);
		s.az = RAW_W'(az);
		s.lvl = MOUTH_W'(lvl);
		pose_queue.push_back(s);
	endtask

	// Random sample. Most are plausible head poses close to the turn points,
	// so that the clamp leaves room for the average to move; the rest cover
	// the documented range and the full width of the ports.
	task automatic queue_random_pose(input int open_pct);
		int pick;
		int r;
		int ax;
		int ay;
		int az;
		int lvl;
		pick = $urandom_range(99);
		if (pick < 60) begin
			r = $urandom_range(12800);
			ax = ($urandom_range(1) != 0) ? 46080 - r : r - 46080;
			ay = int'($urandom_range(10240)) - 5120;
			az = 23040 + int'($urandom_range(20480)) - 10240;
		end else if (pick < 85) begin
			ax = int'($urandom_range(92160)) - 46080;
			ay = int'($urandom_range(92160)) - 46080;
			az = int'($urandom_range(92160)) - 46080;
		end else begin
			ax = $urandom;
			ay = $urandom;
			az = $urandom;
		end
		if ($urandom_range(99) < open_pct)
			lvl = $urandom_range(4095, 52);
		else
			lvl = $urandom_range(51);
		queue_pose(ax, ay, az, lvl);
	endtask

	// Writes one register while the unit is idle and mirrors it locally.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WINDOW_LENGTH: win_len = WLEN_W'(value);
			REG_X_OFFSET:      off_x = CFG_DATA_W'(value);
			REG_Y_OFFSET:      off_y = CFG_DATA_W'(value);
			REG_Z_OFFSET:      off_z = CFG_DATA_W'(value);
			default: ;
		endcase
	endtask

	task automatic set_config(input int len, input int ox, input int oy, input int oz);
		set_reg(REG_WINDOW_LENGTH, len);
		set_reg(REG_X_OFFSET, ox);
		set_reg(REG_Y_OFFSET, oy);
		set_reg(REG_Z_OFFSET, oz);
	endtask

	// Polls at the falling edge, when every assignment of the rising edge has
	// settled, until all samples are through and every result has arrived.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pose_queue.size() != 0 || in_valid || expected_means.size() != 0);
	endtask

	task automatic run_random(input int sidle, input int ridle, input int count,
		input int open_pct);
		@(negedge clk);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		repeat (count)
			queue_random_pose(open_pct);
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed samples at the reset settings: window of eight, no offsets.
		// The window grows from its single zero pose during these.
		@(negedge clk);
		send_idle_pct = 29;
		recv_idle_pct = 72;
		queue_pose(0, 0, 0, 0);                    // zero X is not positive
		queue_pose(1, 0, 23040, 52);               // smallest open level
		queue_pose(-1, 0, 23040, 51);              // largest closed level
		queue_pose(46080, 0, 23040, 4095);
		queue_pose(-46080, 0, 23040, 100);
		queue_pose(38400, 3840, 15360, 60);        // exactly on the lower limits
		queue_pose(-38400, -3840, 30720, 60);      // exactly on the upper limits
		queue_pose(38399, 3841, 15359, 60);        // just past the lower limits
		queue_pose(-38401, -3841, 30721, 60);      // Y and Z just past the upper limits, X just inside
		queue_pose(65535, 65535, 65535, 4095);     // widest positive raw angles
		queue_pose(-65536, -65536, -65536, 0);     // widest negative raw angles
		queue_pose(46080, -46080, 46080, 2048);
		queue_pose(-46080, 46080, -46080, 1);
		// A run of open poses long enough to push every closed one out.
		for (int k = 0; k < 11; k++)
			queue_pose(45000 - 700 * k, 300 * k - 1500, 20000 + 600 * k, 3000 + k);
		wait_drained();

		// Shortest window and the largest documented offsets.
		set_config(1, 11520, 11520, 11520);
		run_random(29, 72, 150, 85);
		// Longest window the register holds, smallest documented offsets.
		set_config(31, -11520, -11520, -11520);
		run_random(29, 72, 180, 97);

		// The window of 31 poses is shrunk to three at the first sample of this phase.
		set_config(3, 16383, -16384, 0);
		run_random(72, 29, 150, 85);
		// A length of zero behaves as one.
		set_config(0, 0, 0, 0);
		run_random(72, 29, 120, 85);
		set_config(20, int'($urandom_range(23040)) - 11520,
			int'($urandom_range(23040)) - 11520, int'($urandom_range(23040)) - 11520);
		run_random(72, 29, 200, 95);

		set_config(8, -16384, 16383, 123);
		run_random(0, 0, 200, 85);
		set_config(12, int'($urandom_range(23040)) - 11520,
			int'($urandom_range(23040)) - 11520, int'($urandom_range(23040)) - 11520);
		run_random(0, 0, 200, 90);
		set_config(2, 0, 0, 0);
		run_random(0, 0, 200, 80);

		// Leave room for any stray result before the verdict.
		repeat (2 * UNIT_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("pose_clamp_moving_average_unit_tb OK");
		else
			$display("pose_clamp_moving_average_unit_tb NOT OK");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("pose_clamp_moving_average_unit_tb NOT OK");
		$finish;
	end

endmodule
